// ----- rtl/cleb_pkg.sv -----
// ----------------------------------------------------------------------------
// cleb_pkg: shared types and constants for the console line edit buffer
// Character codes, default ring depth and the result word layout.
// ----------------------------------------------------------------------------
package cleb_pkg;

  localparam int DefBufferDepth = 128;

  localparam logic [7:0] CH_CTRL_P = 8'h10;
  localparam logic [7:0] CH_CTRL_U = 8'h15;
  localparam logic [7:0] CH_CTRL_H = 8'h08;
  localparam logic [7:0] CH_CTRL_D = 8'h04;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // First member is the most significant, so echo_valid lands in bit 0.
  typedef struct packed {
    logic       read_empty;
    logic       read_eof;
    logic       read_line_end;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       line_committed;
    logic       dump_request;
    logic [7:0] erase_count;
    logic [7:0] echo_char;
    logic       echo_valid;
  } cleb_result_t;

  localparam int ResultBits = $bits(cleb_result_t);

endpackage

// ----- rtl/console_line_edit_buffer.sv -----
// ----------------------------------------------------------------------------
// console_line_edit_buffer: canonical terminal input line buffer
// Line editing, echo and commit of received characters, byte reads.
// ----------------------------------------------------------------------------
// Results: a received character or a read of an empty buffer gives its result
// word in the cycle after acceptance; a read of a committed byte passes through
// the ring memory's registered read port and then the output register.
// One character word per cycle unless the output stalls; a read blocks new words.
// Reset: rst clears the three pointers, the read sequencer and the output valid
// flag; the ring memory keeps its contents and needs no clearing pass.
module console_line_edit_buffer
  import cleb_pkg::*;
#(
  parameter int BUFFER_DEPTH = DefBufferDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // rx_char[7:0], read_started[8], zero fill
  input  logic        s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // echo_valid[0], echo_char[8:1], erase_count[16:9],
                                 // dump_request[17], line_committed[18],
                                 // read_valid[19], read_byte[27:20],
                                 // read_line_end[28], read_eof[29], read_empty[30]
);

  logic         busy;
  logic         acc;
  logic         res_valid;
  cleb_result_t res;
  cleb_result_t out_res;

  assign s_tready = !busy && (!m_tvalid || m_tready);
  assign acc      = s_tvalid && s_tready;

  cleb_core #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .acc      (acc),
    .op       (s_tuser),
    .rx_char  (s_tdata[7:0]),
    .started  (s_tdata[8]),
    .busy     (busy),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {(32 - ResultBits)'(0), out_res};

endmodule

// ----- rtl/cleb_ram.sv -----
// ----------------------------------------------------------------------------
// cleb_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cleb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/cleb_core.sv -----
// ----------------------------------------------------------------------------
// cleb_core: pointer unit and sequencer of the line edit buffer
// Holds the read, commit and edit pointers, edits the line held in the ring
// memory and pops committed bytes through the memory's registered read port.
// ----------------------------------------------------------------------------
module cleb_core
  import cleb_pkg::*;
#(
  parameter int BUFFER_DEPTH = DefBufferDepth
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         acc,
  input  logic         op,
  input  logic [7:0]   rx_char,
  input  logic         started,
  output logic         busy,
  output logic         res_valid,
  output cleb_result_t res
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int PW = AW + 1;
  localparam int XW = PW + 1;
  localparam int SW = (PW > 8) ? PW : 8;
  localparam logic [XW-1:0] SPAN = XW'(2 * BUFFER_DEPTH);
  localparam logic [PW-1:0] DEPTH_P = PW'(BUFFER_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t        state, state_next;
  logic [PW-1:0] read_ptr, read_ptr_next;
  logic [PW-1:0] commit_ptr, commit_ptr_next;
  logic [PW-1:0] edit_ptr, edit_ptr_next;
  logic          started_q;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  logic [PW-1:0] fill;
  logic [PW-1:0] line_len;
  logic [SW-1:0] line_len_ext;
  logic [7:0]    ch;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [XW-1:0] s;
    s = {1'b0, p} + XW'(1);
    return (s >= SPAN) ? '0 : s[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? PW'(2 * BUFFER_DEPTH - 1) : p - PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_diff(input logic [PW-1:0] a,
                                             input logic [PW-1:0] b);
    logic [XW-1:0] d;
    d = (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + SPAN - {1'b0, b});
    return d[PW-1:0];
  endfunction

  function automatic logic [AW-1:0] ptr_index(input logic [PW-1:0] p);
    logic [PW-1:0] i;
    i = (p >= DEPTH_P) ? (p - DEPTH_P) : p;
    return i[AW-1:0];
  endfunction

  cleb_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign fill         = ptr_diff(edit_ptr, read_ptr);
  assign line_len     = ptr_diff(edit_ptr, commit_ptr);
  assign line_len_ext = SW'(line_len);
  assign ch           = (rx_char == CH_CR) ? CH_LF : rx_char;
  assign mem_raddr    = ptr_index(read_ptr);
  assign mem_waddr    = ptr_index(edit_ptr);
  assign mem_wdata    = ch;
  assign busy         = (state != ST_IDLE);

  always_comb begin
    state_next      = state;
    read_ptr_next   = read_ptr;
    commit_ptr_next = commit_ptr;
    edit_ptr_next   = edit_ptr;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    res_valid       = 1'b0;
    res             = '0;
    unique case (state)
      ST_IDLE: begin
        if (acc && !op) begin
          res_valid = 1'b1;
          case (rx_char) inside
            CH_CTRL_P: begin
              res.dump_request = 1'b1;
            end
            CH_CTRL_U: begin
              res.erase_count = (line_len_ext > SW'(255)) ? 8'hFF : line_len_ext[7:0];
              edit_ptr_next   = commit_ptr;
            end
            CH_CTRL_H, CH_DEL: begin
              if (edit_ptr != commit_ptr) begin
                edit_ptr_next   = ptr_dec(edit_ptr);
                res.erase_count = 8'd1;
              end
            end
            default: begin
              if (rx_char != 8'h00 && fill < DEPTH_P) begin
                res.echo_valid = 1'b1;
                res.echo_char  = ch;
                mem_we         = 1'b1;
                edit_ptr_next  = ptr_inc(edit_ptr);
                // The ring becomes full when one slot was left before this write.
                if (ch == CH_LF || ch == CH_CTRL_D || fill == DEPTH_P - PW'(1)) begin
                  commit_ptr_next    = ptr_inc(edit_ptr);
                  res.line_committed = 1'b1;
                end
              end
            end
          endcase
        end else if (acc) begin
          if (read_ptr == commit_ptr) begin
            res_valid      = 1'b1;
            res.read_empty = 1'b1;
          end else begin
            mem_re     = 1'b1;
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        res_valid  = 1'b1;
        state_next = ST_IDLE;
        if (mem_rdata == CH_CTRL_D) begin
          res.read_eof = 1'b1;
          // An end-of-file mark stays put if this read already returned bytes.
          if (!started_q) begin
            read_ptr_next = ptr_inc(read_ptr);
          end
        end else begin
          read_ptr_next     = ptr_inc(read_ptr);
          res.read_valid    = 1'b1;
          res.read_byte     = mem_rdata;
          res.read_line_end = (mem_rdata == CH_LF);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      read_ptr   <= '0;
      commit_ptr <= '0;
      edit_ptr   <= '0;
    end else begin
      state      <= state_next;
      read_ptr   <= read_ptr_next;
      commit_ptr <= commit_ptr_next;
      edit_ptr   <= edit_ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      started_q <= started;
    end
  end

endmodule

// ----- rtl/cleb_checker.sv -----
// ----------------------------------------------------------------------------
// cleb_checker: port-level checks for the console line edit buffer
// Watches the output stream for consistency of each result word.
// ----------------------------------------------------------------------------
module cleb_checker
  import cleb_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  cleb_result_t r;
  assign r = m_tdata[ResultBits-1:0];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // A word reports one kind of event only.
  a_one_event: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0({r.echo_valid, r.dump_request, r.read_valid,
                           r.read_eof, r.read_empty, (r.erase_count != 8'd0)}))
    else $error("result word mixes events");

  a_commit_echo: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.line_committed |-> r.echo_valid)
    else $error("line committed without a stored character");

  a_echo_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.echo_valid |-> r.echo_char != CH_CR && r.echo_char != 8'h00)
    else $error("carriage return or zero byte echoed");

  a_line_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.read_line_end |-> r.read_valid && r.read_byte == CH_LF)
    else $error("line end flagged on a byte other than newline");

endmodule

bind console_line_edit_buffer cleb_checker u_cleb_checker (.*);

// ----- bench/tb_console_line_edit_buffer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_console_line_edit_buffer: self-checking bench for the console line buffer
// Drives received characters and read requests over the input stream, keeps
// its own copy of the ring and its pointers, and compares every result word
// with the predicted one, field by field, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_console_line_edit_buffer;
  import cleb_pkg::*;

  localparam int Depth = DefBufferDepth;
  localparam int PtrW = $clog2(2 * Depth);
  localparam bit OP_RX = 1'b0;
  localparam bit OP_READ = 1'b1;
  localparam int BacklogCycles = 300;

  typedef logic [PtrW-1:0] ptr_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // rx_char[7:0], read_started[8], zero fill
  logic        s_tuser;   // operation
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // echo_valid[0], echo_char[8:1], erase_count[16:9],
                          // dump_request[17], line_committed[18],
                          // read_valid[19], read_byte[27:20],
                          // read_line_end[28], read_eof[29], read_empty[30]

  // Shadow copy of the ring and its three pointers.
  logic [7:0]   ring_copy [Depth];
  ptr_t         read_ptr;
  ptr_t         commit_ptr;
  ptr_t         edit_ptr;

  cleb_result_t expected_words [$];
  cleb_result_t last_prediction;
  cleb_result_t got_word;
  cleb_result_t want_word;
  bit           idle_on;
  bit           backlog_hold;
  bit           failed;
  int unsigned  words_sent;

  console_line_edit_buffer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_console_line_edit_buffer failed");
    $finish;
  end

  function automatic cleb_result_t predict_word(bit op, logic [7:0] ch, bit started);
    cleb_result_t r;
    logic [7:0]   c;
    logic [7:0]   b;
    int unsigned  n;
    r = '0;
    c = ch;
    if (op == OP_RX) begin
      if (c == CH_CTRL_P) begin
        r.dump_request = 1'b1;
      end else if (c == CH_CTRL_U) begin
        n = ptr_t'(edit_ptr - commit_ptr);
        r.erase_count = (n > 255) ? 8'd255 : n[7:0];
        edit_ptr = commit_ptr;
      end else if (c == CH_CTRL_H || c == CH_DEL) begin
        if (edit_ptr != commit_ptr) begin
          edit_ptr = edit_ptr - 1'b1;
          r.erase_count = 8'd1;
        end
      end else if (c != 8'd0 && ptr_t'(edit_ptr - read_ptr) < Depth) begin
        if (c == CH_CR) c = CH_LF;
        r.echo_valid = 1'b1;
        r.echo_char = c;
        ring_copy[edit_ptr[PtrW-2:0]] = c;
        edit_ptr = edit_ptr + 1'b1;
        // A full ring commits the line even without a terminator.
        if (c == CH_LF || c == CH_CTRL_D || ptr_t'(edit_ptr - read_ptr) == Depth) begin
          commit_ptr = edit_ptr;
          r.line_committed = 1'b1;
        end
      end
    end else begin
      if (read_ptr == commit_ptr) begin
        r.read_empty = 1'b1;
      end else begin
        b = ring_copy[read_ptr[PtrW-2:0]];
        if (b == CH_CTRL_D) begin
          // End of file is left in place when the call already got bytes.
          r.read_eof = 1'b1;
          if (!started) read_ptr = read_ptr + 1'b1;
        end else begin
          read_ptr = read_ptr + 1'b1;
          r.read_valid = 1'b1;
          r.read_byte = b;
          r.read_line_end = (b == CH_LF);
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        last_prediction = predict_word(s_tuser, s_tdata[7:0], s_tdata[8]);
        expected_words.push_back(last_prediction);
      end
      if (m_tvalid && m_tready) begin
        got_word = cleb_result_t'(m_tdata[ResultBits-1:0]);
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: %h", m_tdata);
          failed = 1'b1;
        end else begin
          want_word = expected_words.pop_front();
          check_field("echo_valid", want_word.echo_valid, got_word.echo_valid);
          check_field("echo_char", want_word.echo_char, got_word.echo_char);
          check_field("erase_count", want_word.erase_count, got_word.erase_count);
          check_field("dump_request", want_word.dump_request, got_word.dump_request);
          check_field("line_committed", want_word.line_committed, got_word.line_committed);
          check_field("read_valid", want_word.read_valid, got_word.read_valid);
          check_field("read_byte", want_word.read_byte, got_word.read_byte);
          check_field("read_line_end", want_word.read_line_end, got_word.read_line_end);
          check_field("read_eof", want_word.read_eof, got_word.read_eof);
          check_field("read_empty", want_word.read_empty, got_word.read_empty);
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (backlog_hold) begin
        m_tready <= 1'b0;
        repeat (BacklogCycles) @(negedge clk);
        backlog_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Called and returning at a falling edge; returns once the word is taken.
  task automatic send_word(bit op, logic [7:0] ch, bit started);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {7'd0, started, ch};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    words_sent++;
  endtask

  // One read call: pops committed bytes until a line end or an empty ring, or
  // until its budget of read words runs out; an end of file does not end it.
  task automatic read_call(int unsigned budget);
    bit started;
    started = 1'b0;
    repeat (budget) begin
      send_word(OP_READ, 8'($urandom), ($urandom_range(0, 15) == 0) ? ~started : started);
      if (last_prediction.read_empty || last_prediction.read_line_end) break;
      started = last_prediction.read_valid;
      if (last_prediction.read_eof) started = 1'b0;
    end
  endtask

  task automatic drain_ring(int unsigned budget);
    int unsigned left;
    left = budget;
    while (left > 0) begin
      read_call(left);
      if (last_prediction.read_empty) break;
      left--;
    end
  endtask

  task automatic type_line(int unsigned len);
    int unsigned pick;
    logic [7:0]  ch;
    repeat (len) begin
      pick = $urandom_range(0, 39);
      if (pick < 2) ch = CH_CTRL_H;
      else if (pick < 4) ch = CH_DEL;
      else if (pick == 4) ch = CH_CTRL_U;
      else if (pick == 5) ch = CH_CTRL_P;
      else if (pick < 9) ch = 8'($urandom);
      else ch = 8'($urandom_range(8'h20, 8'h7E));
      send_word(OP_RX, ch, 1'($urandom));
    end
    pick = $urandom_range(0, 9);
    if (pick < 4) send_word(OP_RX, CH_LF, 1'($urandom));
    else if (pick < 7) send_word(OP_RX, CH_CR, 1'($urandom));
    else if (pick < 9) send_word(OP_RX, CH_CTRL_D, 1'($urandom));
  endtask

  task automatic test_directed_cases();
    send_word(OP_RX, CH_CTRL_P, 1'b0);
    send_word(OP_RX, CH_CTRL_U, 1'b0);
    send_word(OP_RX, CH_CTRL_H, 1'b1);
    send_word(OP_RX, CH_DEL, 1'b0);
    send_word(OP_RX, 8'h00, 1'b1);
    send_word(OP_READ, 8'hFF, 1'b0);
    send_word(OP_RX, 8'h61, 1'b0);
    send_word(OP_RX, 8'hFF, 1'b0);
    send_word(OP_RX, CH_CTRL_H, 1'b0);
    send_word(OP_RX, 8'h62, 1'b0);
    send_word(OP_RX, 8'h63, 1'b0);
    send_word(OP_RX, CH_CTRL_U, 1'b0);
    send_word(OP_RX, 8'h78, 1'b0);
    send_word(OP_RX, CH_CR, 1'b0);
    send_word(OP_READ, 8'h00, 1'b0);
    send_word(OP_READ, 8'h00, 1'b1);
    send_word(OP_RX, CH_CTRL_D, 1'b0);
    send_word(OP_RX, CH_DEL, 1'b0);
    send_word(OP_READ, 8'h00, 1'b1);
    send_word(OP_READ, 8'h00, 1'b0);
    send_word(OP_READ, 8'h00, 1'b1);
  endtask

  // Fills the ring while the receiver holds off, so the block backs up.
  task automatic test_ring_full();
    backlog_hold = 1'b1;
    for (int i = 0; i < Depth; i++) send_word(OP_RX, 8'(8'h41 + i % 26), 1'b0);
    send_word(OP_RX, 8'h5A, 1'b0);
    send_word(OP_RX, CH_CTRL_H, 1'b0);
    send_word(OP_RX, CH_CTRL_U, 1'b0);
    drain_ring(Depth + 2);
  endtask

  task automatic test_random_sessions(int unsigned stop_at);
    int unsigned pick;
    while (words_sent < stop_at) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) type_line($urandom_range(0, 12));
      else if (pick == 12) type_line($urandom_range(60, 140));
      else if (pick < 17) drain_ring(ptr_t'(commit_ptr - read_ptr) + 2);
      else if (pick < 19) read_call($urandom_range(1, 6));
      else send_word(1'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = 1'b0;
    s_tdata = '0;
    idle_on = 1'b1;
    backlog_hold = 1'b0;
    failed = 1'b0;
    words_sent = 0;
    read_ptr = '0;
    commit_ptr = '0;
    edit_ptr = '0;
    last_prediction = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_cases();
    test_ring_full();
    test_random_sessions(1250);
    idle_on = 1'b0;
    test_random_sessions(1400);
    drain_ring(ptr_t'(commit_ptr - read_ptr) + 2);
    s_tvalid <= 1'b0;

    wait (expected_words.size() == 0);
    repeat (8) @(posedge clk);
    if (!failed) begin
      $display("tb_console_line_edit_buffer passed");
    end else begin
      $display("tb_console_line_edit_buffer failed");
    end
    $finish;
  end

endmodule
